/* hw/rtl/q2e_pkg.sv */
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and tables for the quaternion to Euler converter.
// ----------------------------------------------------------------------------
`default_nettype none

package q2e_pkg;

	localparam int CORDIC_STAGES_DEF = 16;
	localparam int ANGLE_BITS_DEF    = 16;
	localparam int QW                = 16;
	localparam int OUT_W             = 16;
	localparam int TABLE_LEN         = 24;
	// vector components are at most about 2^32 in magnitude, growth below 2^34
	localparam int VW                = 36;
	localparam int SQW               = 58;
	localparam int SQRT_STEPS        = 29;

	typedef struct packed {
		logic signed [QW-1:0] quat_w;
		logic signed [QW-1:0] quat_x;
		logic signed [QW-1:0] quat_y;
		logic signed [QW-1:0] quat_z;
	} q2e_in_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] pitch_angle;
		logic signed [OUT_W-1:0] yaw_angle;
		logic signed [OUT_W-1:0] roll_angle;
		logic                    pitch_clamped;
	} q2e_out_t;

	function automatic logic [31:0] atan_entry(input int i);
		logic [31:0] r;
		case (i)
			0: r = 32'd536870912;
			1: r = 32'd316933406;
			2: r = 32'd167458907;
			3: r = 32'd85004756;
			4: r = 32'd42667331;
			5: r = 32'd21354465;
			6: r = 32'd10679838;
			7: r = 32'd5340245;
			8: r = 32'd2670163;
			9: r = 32'd1335087;
			10: r = 32'd667544;
			11: r = 32'd333772;
			12: r = 32'd166886;
			13: r = 32'd83443;
			14: r = 32'd41722;
			15: r = 32'd20861;
			16: r = 32'd10430;
			17: r = 32'd5215;
			18: r = 32'd2608;
			19: r = 32'd1304;
			20: r = 32'd652;
			21: r = 32'd326;
			22: r = 32'd163;
			23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// stage angle rounded half up to ab bits, pi = 2^(ab-1)
	function automatic logic [32:0] stage_angle(input int i, input int ab);
		logic [32:0] t;
		t = {1'b0, atan_entry(i)} + (33'd1 << (31 - ab));
		return t >> (32 - ab);
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/quaternion_to_euler_top.sv */
// ----------------------------------------------------------------------------
// quaternion_to_euler_top
// Unit quaternion to Y-X-Z Euler angles through CORDIC and square-root chains.
// ----------------------------------------------------------------------------
// Fully pipelined: busy is never raised and a new quaternion is taken every
// cycle. Each result appears on result with done high for one cycle, once the
// product, sum and square registers, the square-root chain in front of the
// pitch CORDIC and that CORDIC are passed; the receiver cannot stall.
`default_nettype none

module quaternion_to_euler_top #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_BITS    = q2e_pkg::ANGLE_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire  q2e_pkg::q2e_in_t  operand,
	output logic                done,
	output q2e_pkg::q2e_out_t   result
);

	localparam int VW  = q2e_pkg::VW;
	localparam int SQW = q2e_pkg::SQW;
	localparam int NS  = q2e_pkg::SQRT_STEPS;
	localparam int N   = (CORDIC_STAGES < q2e_pkg::TABLE_LEN) ?
		CORDIC_STAGES : q2e_pkg::TABLE_LEN;
	localparam int LAT = 2 + NS + 2 + N + 1;
	localparam int DL  = NS + 1;
	localparam logic signed [VW-1:0] ONE = VW'(1) << 28;

	assign busy = 1'b0;

	// stage 1: products
	logic signed [31:0] wx_s1, yz_s1, wy_s1, zx_s1, xx_s1, yy_s1, wz_s1, xy_s1, zz_s1;
	always_ff @(posedge clk) begin
		wx_s1 <= operand.quat_w * operand.quat_x;
		yz_s1 <= operand.quat_y * operand.quat_z;
		wy_s1 <= operand.quat_w * operand.quat_y;
		zx_s1 <= operand.quat_z * operand.quat_x;
		xx_s1 <= operand.quat_x * operand.quat_x;
		yy_s1 <= operand.quat_y * operand.quat_y;
		wz_s1 <= operand.quat_w * operand.quat_z;
		xy_s1 <= operand.quat_x * operand.quat_y;
		zz_s1 <= operand.quat_z * operand.quat_z;
	end

	// stage 2: sums and clamp
	logic signed [VW-1:0] t_raw;
	logic signed [VW-1:0] t_s2, yn_s2, yd_s2, rn_s2, rd_s2;
	logic                 clamp_s2;
	assign t_raw = (VW'(wx_s1) - VW'(yz_s1)) <<< 1;
	always_ff @(posedge clk) begin
		if (t_raw > ONE) begin
			t_s2 <= ONE;
			clamp_s2 <= 1'b1;
		end else if (t_raw < -ONE) begin
			t_s2 <= -ONE;
			clamp_s2 <= 1'b1;
		end else begin
			t_s2 <= t_raw;
			clamp_s2 <= 1'b0;
		end
		yn_s2 <= (VW'(wy_s1) + VW'(zx_s1)) <<< 1;
		yd_s2 <= ONE - ((VW'(xx_s1) + VW'(yy_s1)) <<< 1);
		rn_s2 <= (VW'(wz_s1) + VW'(xy_s1)) <<< 1;
		rd_s2 <= ONE - ((VW'(xx_s1) + VW'(zz_s1)) <<< 1);
	end

	// square of t, registered; |t| <= 2^28 so 29-bit magnitude
	logic [28:0] tmag;
	logic [SQW-1:0] rad_s3;
	logic signed [VW-1:0] t_s3;
	assign tmag = t_s2[VW-1] ? 29'(-t_s2) : 29'(t_s2);
	always_ff @(posedge clk) begin
		rad_s3 <= (SQW'(1) << 56) - SQW'(tmag) * SQW'(tmag);
		t_s3   <= t_s2;
	end

	logic [SQW-1:0] rem [0:NS];
	logic [SQW-1:0] res [0:NS];
	logic           sv  [0:NS];
	assign rem[0] = rad_s3;
	assign res[0] = '0;
	assign sv[0]  = 1'b0;

	for (genvar k = 0; k < NS; k++) begin : g_sqrt
		q2e_sqrt_cell #(.K(NS - 1 - k)) u_sq (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (sv[k]),
			.rem_in  (rem[k]),
			.res_in  (res[k]),
			.vld_out (sv[k+1]),
			.rem_out (rem[k+1]),
			.res_out (res[k+1])
		);
	end

	// delay lines to align t with sqrt and yaw/roll with pitch
	logic signed [VW-1:0] td_q [0:NS-1];
	logic signed [VW-1:0] ynd_q [0:DL-1];
	logic signed [VW-1:0] ydd_q [0:DL-1];
	logic signed [VW-1:0] rnd_q [0:DL-1];
	logic signed [VW-1:0] rdd_q [0:DL-1];
	logic                 cl_q  [0:LAT-3];
	always_ff @(posedge clk) begin
		td_q[0]  <= t_s3;
		ynd_q[0] <= yn_s2;
		ydd_q[0] <= yd_s2;
		rnd_q[0] <= rn_s2;
		rdd_q[0] <= rd_s2;
		cl_q[0]  <= clamp_s2;
		for (int i = 1; i < NS; i++) td_q[i] <= td_q[i-1];
		for (int i = 1; i < DL; i++) begin
			ynd_q[i] <= ynd_q[i-1];
			ydd_q[i] <= ydd_q[i-1];
			rnd_q[i] <= rnd_q[i-1];
			rdd_q[i] <= rdd_q[i-1];
		end
		for (int i = 1; i < LAT - 2; i++) cl_q[i] <= cl_q[i-1];
	end

	logic signed [q2e_pkg::OUT_W-1:0] pa, ya, ra;

	q2e_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_pitch (
		.clk(clk), .y(td_q[NS-1]), .x(VW'(res[NS])), .angle(pa));
	q2e_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_yaw (
		.clk(clk), .y(ynd_q[DL-1]), .x(ydd_q[DL-1]), .angle(ya));
	q2e_atan2 #(.CORDIC_STAGES(CORDIC_STAGES), .ANGLE_BITS(ANGLE_BITS)) u_roll (
		.clk(clk), .y(rnd_q[DL-1]), .x(rdd_q[DL-1]), .angle(ra));

	logic [LAT-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start};
		end
	end

	assign done                 = vld_q[LAT-1];
	assign result.pitch_angle   = pa;
	assign result.yaw_angle     = ya;
	assign result.roll_angle    = ra;
	assign result.pitch_clamped = cl_q[LAT-3];

endmodule

`default_nettype wire

/* hw/rtl/q2e_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// q2e_sqrt_cell
// One digit-by-digit step of the integer square root, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_sqrt_cell #(
	parameter int K = 28
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               vld_in,
	input  wire  [q2e_pkg::SQW-1:0]           rem_in,
	input  wire  [q2e_pkg::SQW-1:0]           res_in,
	output logic                              vld_out,
	output logic [q2e_pkg::SQW-1:0]           rem_out,
	output logic [q2e_pkg::SQW-1:0]           res_out
);

	localparam logic [q2e_pkg::SQW-1:0] BIT = q2e_pkg::SQW'(1) << (2 * K);

	logic [q2e_pkg::SQW-1:0] trial;

	assign trial = res_in + BIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (rem_in >= trial) begin
			rem_out <= rem_in - trial;
			res_out <= (res_in >> 1) + BIT;
		end else begin
			rem_out <= rem_in;
			res_out <= res_in >> 1;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/q2e_cordic_cell.sv */
// ----------------------------------------------------------------------------
// q2e_cordic_cell
// One vectoring CORDIC micro-rotation, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_cordic_cell #(
	parameter int I          = 0,
	parameter int ANGLE_BITS = q2e_pkg::ANGLE_BITS_DEF
) (
	input  wire                                clk,
	input  wire  signed [q2e_pkg::VW-1:0]      x_in,
	input  wire  signed [q2e_pkg::VW-1:0]      y_in,
	input  wire  signed [ANGLE_BITS+1:0]       z_in,
	output logic signed [q2e_pkg::VW-1:0]      x_out,
	output logic signed [q2e_pkg::VW-1:0]      y_out,
	output logic signed [ANGLE_BITS+1:0]       z_out
);

	localparam logic signed [ANGLE_BITS+1:0] ANG =
		(ANGLE_BITS+2)'(q2e_pkg::stage_angle(I, ANGLE_BITS));

	logic signed [q2e_pkg::VW-1:0] dx, dy;

	assign dx = y_in >>> I;
	assign dy = x_in >>> I;

	always_ff @(posedge clk) begin
		if (!y_in[q2e_pkg::VW-1]) begin
			x_out <= x_in + dx;
			y_out <= y_in - dy;
			z_out <= z_in + ANG;
		end else begin
			x_out <= x_in - dx;
			y_out <= y_in + dy;
			z_out <= z_in - ANG;
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/q2e_atan2.sv */
// ----------------------------------------------------------------------------
// q2e_atan2
// Pipelined atan2: quadrant fold, a chain of CORDIC cells, output scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module q2e_atan2 #(
	parameter int CORDIC_STAGES = q2e_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_BITS    = q2e_pkg::ANGLE_BITS_DEF
) (
	input  wire                                clk,
	input  wire  signed [q2e_pkg::VW-1:0]      y,
	input  wire  signed [q2e_pkg::VW-1:0]      x,
	output logic signed [q2e_pkg::OUT_W-1:0]   angle
);

	localparam int N  = (CORDIC_STAGES < q2e_pkg::TABLE_LEN) ?
		CORDIC_STAGES : q2e_pkg::TABLE_LEN;
	localparam int ZW = ANGLE_BITS + 2;
	localparam int SH = ANGLE_BITS - q2e_pkg::OUT_W;
	localparam logic signed [ZW-1:0] PI = ZW'(1) << (ANGLE_BITS - 1);

	logic signed [q2e_pkg::VW-1:0] xc [0:N];
	logic signed [q2e_pkg::VW-1:0] yc [0:N];
	logic signed [ZW-1:0]          zc [0:N];
	logic                          zero_s [0:N];

	always_ff @(posedge clk) begin
		if (x < 0) begin
			xc[0] <= -x;
			yc[0] <= -y;
			zc[0] <= (y >= 0) ? PI : -PI;
		end else begin
			xc[0] <= x;
			yc[0] <= y;
			zc[0] <= '0;
		end
		zero_s[0] <= (x == 0) && (y == 0);
	end

	for (genvar i = 0; i < N; i++) begin : g_cell
		q2e_cordic_cell #(.I(i), .ANGLE_BITS(ANGLE_BITS)) u_cell (
			.clk   (clk),
			.x_in  (xc[i]),
			.y_in  (yc[i]),
			.z_in  (zc[i]),
			.x_out (xc[i+1]),
			.y_out (yc[i+1]),
			.z_out (zc[i+1])
		);
		always_ff @(posedge clk) begin
			zero_s[i+1] <= zero_s[i];
		end
	end

	logic signed [ZW-1:0] zf;
	assign zf = zero_s[N] ? '0 : zc[N];

	if (SH > 0) begin : g_down
		logic signed [ZW-1:0] zr;
		assign zr = zf + (ZW'(1) << (SH - 1));
		always_ff @(posedge clk) begin
			angle <= q2e_pkg::OUT_W'(zr >>> SH);
		end
	end else begin : g_up
		logic signed [ZW+q2e_pkg::OUT_W-1:0] zx;
		assign zx = (ZW+q2e_pkg::OUT_W)'(zf) <<< (-SH);
		always_ff @(posedge clk) begin
			angle <= q2e_pkg::OUT_W'(zx);
		end
	end

endmodule

`default_nettype wire

/* bench/tb_quaternion_to_euler_top.sv */
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_top
// Self-checking bench for the quaternion to Euler converter. Directed corner
// quaternions, then random unit and non-unit quaternions with random start
// gaps; every result is compared with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
`default_nettype none

class euler_scoreboard;
	q2e_pkg::q2e_out_t pending_angles[$];
	int n_sent;
	int n_checked;
	int n_errors;
	int n_clamped;

	function longint floor_shift(longint v, int s);
		return v >>> s;
	endfunction

	function longint step_angle(int i);
		longint t;
		t = longint'(q2e_pkg::atan_entry(i % q2e_pkg::TABLE_LEN));
		return (t + (64'sd1 << (32 - q2e_pkg::ANGLE_BITS_DEF - 1)))
			>>> (32 - q2e_pkg::ANGLE_BITS_DEF);
	endfunction

	function logic [15:0] vector_angle(longint yv, longint xv);
		longint acc, dx, dy, pi_val;
		int s;
		pi_val = 64'sd1 << (q2e_pkg::ANGLE_BITS_DEF - 1);
		acc = 0;
		if (xv == 0 && yv == 0) return 16'd0;
		if (xv < 0) begin
			acc = (yv >= 0) ? pi_val : -pi_val;
			xv = -xv;
			yv = -yv;
		end
		for (int i = 0; i < q2e_pkg::CORDIC_STAGES_DEF && i < q2e_pkg::TABLE_LEN; i++) begin
			dx = floor_shift(yv, i);
			dy = floor_shift(xv, i);
			if (yv >= 0) begin
				xv += dx;
				yv -= dy;
				acc += step_angle(i);
			end else begin
				xv -= dx;
				yv += dy;
				acc -= step_angle(i);
			end
		end
		s = q2e_pkg::ANGLE_BITS_DEF - 16;
		if (s > 0) acc = floor_shift(acc + (64'sd1 << (s - 1)), s);
		else if (s < 0) acc = acc <<< (-s);
		return acc[15:0];
	endfunction

	function longint int_sqrt(longint unsigned v);
		longint unsigned res, b;
		res = 0;
		for (int k = 28; k >= 0; k--) begin
			b = 64'd1 << (2 * k);
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
		end
		return longint'(res);
	endfunction

	function void note_quat(q2e_pkg::q2e_in_t q);
		longint w, x, y, z, t, c, one;
		q2e_pkg::q2e_out_t e;
		one = 64'sd1 << 28;
		w = q.quat_w;
		x = q.quat_x;
		y = q.quat_y;
		z = q.quat_z;
		t = 2 * (w * x - y * z);
		e.pitch_clamped = 1'b0;
		if (t > one) begin
			t = one;
			e.pitch_clamped = 1'b1;
		end else if (t < -one) begin
			t = -one;
			e.pitch_clamped = 1'b1;
		end
		c = int_sqrt((64'd1 << 56) - longint'(t * t));
		e.pitch_angle = vector_angle(t, c);
		e.yaw_angle = vector_angle(2 * (w * y + z * x), one - 2 * (x * x + y * y));
		e.roll_angle = vector_angle(2 * (w * z + x * y), one - 2 * (x * x + z * z));
		pending_angles.push_back(e);
		n_sent++;
		if (e.pitch_clamped) n_clamped++;
	endfunction

	function void check_result(q2e_pkg::q2e_out_t got);
		q2e_pkg::q2e_out_t e;
		if (pending_angles.size() == 0) begin
			$display("%t unexpected result %h", $realtime, got);
			n_errors++;
			return;
		end
		e = pending_angles.pop_front();
		n_checked++;
		if (got.pitch_angle !== e.pitch_angle) begin
			$display("%t pitch exp %0d got %0d", $realtime, e.pitch_angle, got.pitch_angle);
			n_errors++;
		end
		if (got.yaw_angle !== e.yaw_angle) begin
			$display("%t yaw exp %0d got %0d", $realtime, e.yaw_angle, got.yaw_angle);
			n_errors++;
		end
		if (got.roll_angle !== e.roll_angle) begin
			$display("%t roll exp %0d got %0d", $realtime, e.roll_angle, got.roll_angle);
			n_errors++;
		end
		if (got.pitch_clamped !== e.pitch_clamped) begin
			$display("%t clamp exp %0b got %0b", $realtime, e.pitch_clamped,
				got.pitch_clamped);
			n_errors++;
		end
	endfunction
endclass

module tb_quaternion_to_euler_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 2 + 29 + 2 + 16 + 1;
	localparam int WATCHDOG_LIMIT = 4 * (LATENCY + 16) + 100;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	q2e_pkg::q2e_in_t operand;
	q2e_pkg::q2e_out_t result;
	euler_scoreboard sb;
	int idle_cycles;
	bit timed_out;

	quaternion_to_euler_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.operand(operand),
		.done(done),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && done) sb.check_result(result);
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
			timed_out = 1'b1;
			$display("stalled after %0d of %0d quaternions checked",
				sb.n_checked, sb.n_sent);
			$display("FAILED: results differ");
			$finish;
		end
	end

	function automatic logic signed [15:0] rand_comp();
		return 16'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	// random unit quaternion, normalized in real arithmetic
	function automatic q2e_pkg::q2e_in_t rand_unit();
		real a[4];
		real n;
		q2e_pkg::q2e_in_t q;
		n = 0.0;
		foreach (a[i]) begin
			a[i] = real'(int'($urandom_range(0, 65534)) - 32767);
			n += a[i] * a[i];
		end
		if (n == 0.0) begin
			a[0] = 1.0;
			n = 1.0;
		end
		n = $sqrt(n);
		q.quat_w = 16'($rtoi(a[0] / n * 16384.0));
		q.quat_x = 16'($rtoi(a[1] / n * 16384.0));
		q.quat_y = 16'($rtoi(a[2] / n * 16384.0));
		q.quat_z = 16'($rtoi(a[3] / n * 16384.0));
		return q;
	endfunction

	task automatic send_quat(q2e_pkg::q2e_in_t q, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		operand <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_quat(q);
	endtask

	task automatic send_burst(q2e_pkg::q2e_in_t q);
		// back-to-back: keep start high across transactions
		start <= 1'b1;
		operand <= q;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note_quat(q);
	endtask

	initial begin
		q2e_pkg::q2e_in_t q;
		logic signed [15:0] corner[5];
		int gap;
		sb = new();
		idle_cycles = 0;
		timed_out = 1'b0;
		start = 1'b0;
		operand = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		corner = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd11585, -16'sd11585};
		send_quat('{16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 0);
		send_quat('{16'sd0, 16'sd16384, 16'sd0, 16'sd0}, 1);
		send_quat('{16'sd0, 16'sd0, 16'sd16384, 16'sd0}, 0);
		send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd16384}, 2);
		send_quat('{-16'sd16384, 16'sd0, 16'sd0, 16'sd0}, 0);
		send_quat('{16'sd0, 16'sd0, 16'sd0, 16'sd0}, 0);
		send_quat('{16'sd11585, 16'sd11585, 16'sd0, 16'sd0}, 3);
		send_quat('{16'sd11585, -16'sd11585, 16'sd0, 16'sd0}, 0);
		send_quat('{16'sd16384, 16'sd16384, 16'sd0, 16'sd0}, 0);
		send_quat('{16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384}, 1);
		send_quat('{-16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384}, 0);
		send_quat('{16'sd0, 16'sd11585, 16'sd11585, 16'sd0}, 0);
		send_quat('{16'sd0, 16'sd0, 16'sd11585, 16'sd11585}, 0);
		send_quat('{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192}, 2);
		send_quat('{-16'sd8192, 16'sd8192, -16'sd8192, 16'sd8192}, 0);
		send_quat('{16'sd0, 16'sd0, 16'sd16384, -16'sd16384}, 0);
		send_quat('{16'sd0, -16'sd1, 16'sd0, 16'sd0}, 0);
		send_quat('{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 0);
		send_quat('{16'sd32767, 16'sd32767, 16'sd32767, -16'sd32768}, 1);
		send_quat('{16'sd0, 16'sd0, -16'sd32768, -16'sd32768}, 0);
		send_quat('{-16'sd1, -16'sd1, -16'sd1, -16'sd1}, 0);

		for (int n = 0; n < 2000; n++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: q = rand_unit();
				6: begin
					q = rand_unit();
					q.quat_x = corner[$urandom_range(0, 4)];
					q.quat_z = corner[$urandom_range(0, 4)];
				end
				7: q = '{rand_comp(), rand_comp(), rand_comp(), rand_comp()};
				default: q = q2e_pkg::q2e_in_t'({$urandom(), $urandom()});
			endcase
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0;
			if (n % 400 < 100) send_burst(q);
			else send_quat(q, gap);
		end
		start <= 1'b0;

		while (sb.pending_angles.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("checked %0d of %0d quaternions, %0d with clamped pitch",
			sb.n_checked, sb.n_sent, sb.n_clamped);
		if (sb.n_errors == 0 && sb.pending_angles.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

`default_nettype wire
